FILE: hdl/rbei_pkg.sv
// Shared types, constants and tables for the random bit error injector.
`default_nettype none
package rbei_pkg;

    localparam logic [28:0] ONE_Q28  = 29'h1000_0000;
    localparam logic [35:0] TERM_ONE = 36'h8_0000_0000;

    localparam logic [29:0] RECIP7  = 30'd613566756;
    localparam logic [29:0] RECIP35 = 30'd122713351;

    localparam logic [1:0] KIND_CLEAR = 2'd0;
    localparam logic [1:0] KIND_SET   = 2'd1;
    localparam logic [1:0] KIND_FLIP  = 2'd2;

    localparam logic [1:0] REG_PROB   = 2'd0;
    localparam logic [1:0] REG_MODE   = 2'd1;
    localparam logic [1:0] REG_ACTIVE = 2'd2;

    typedef logic [7:0][28:0] thr_arr_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       active;
        logic       busy;
    } ctrl_t;

    localparam logic [8:0] GROUP_START [10] = '{
        9'd0, 9'd1, 9'd9, 9'd37, 9'd93, 9'd163, 9'd219, 9'd247, 9'd255, 9'd256
    };

    localparam logic [7:0] MASK_TABLE [256] = '{
        8'h00,
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
        8'h03, 8'h06, 8'h0C, 8'h18, 8'h30, 8'h60, 8'hC0, 8'h81,
        8'h05, 8'h0A, 8'h14, 8'h28, 8'h50, 8'hA0, 8'h41, 8'h82,
        8'h09, 8'h12, 8'h24, 8'h48, 8'h90, 8'h21, 8'h42, 8'h84,
        8'h11, 8'h22, 8'h44, 8'h88,
        8'h07, 8'h0E, 8'h1C, 8'h38, 8'h70, 8'hE0, 8'hC1, 8'h83,
        8'h0B, 8'h16, 8'h2C, 8'h58, 8'hB0, 8'h61, 8'hC2, 8'h85,
        8'h13, 8'h26, 8'h4C, 8'h98, 8'h31, 8'h62, 8'hC4, 8'h89,
        8'h0D, 8'h1A, 8'h34, 8'h68, 8'hD0, 8'hA1, 8'h43, 8'h86,
        8'h19, 8'h32, 8'h64, 8'hC8, 8'h91, 8'h23, 8'h46, 8'h8C,
        8'h15, 8'h2A, 8'h54, 8'hA8, 8'h51, 8'hA2, 8'h45, 8'h8A,
        8'h25, 8'h4A, 8'h94, 8'h29, 8'h52, 8'hA4, 8'h49, 8'h92,
        8'h0F, 8'h1E, 8'h3C, 8'h78, 8'hF0, 8'hE1, 8'hC3, 8'h87,
        8'h17, 8'h2E, 8'h5C, 8'hB8, 8'h71, 8'hE2, 8'hC5, 8'h8B,
        8'h27, 8'h4E, 8'h9C, 8'h39, 8'h72, 8'hE4, 8'hC9, 8'h93,
        8'h1B, 8'h35, 8'h6C, 8'hD8, 8'hB1, 8'h53, 8'hC6, 8'h8D,
        8'h2B, 8'h56, 8'hAC, 8'h59, 8'hB2, 8'h65, 8'hCA, 8'h95,
        8'h33, 8'h66, 8'hCC, 8'h99,
        8'h1D, 8'h3A, 8'h74, 8'hE8, 8'hD1, 8'hA3, 8'h47, 8'h8E,
        8'h2D, 8'h5A, 8'hB4, 8'h69, 8'hD2, 8'hA5, 8'h4B, 8'h96,
        8'h35, 8'h6A, 8'hD4, 8'hA9, 8'h53, 8'hA6, 8'h4D, 8'h9A,
        8'h55, 8'hAA,
        8'hF8, 8'hF1, 8'hE3, 8'hC7, 8'h8F, 8'h1F, 8'h3E, 8'h7C,
        8'hF4, 8'hE9, 8'hD3, 8'hA7, 8'h4F, 8'h9E, 8'h3D, 8'h7A,
        8'hEC, 8'hD9, 8'hB3, 8'h67, 8'hCE, 8'h9D, 8'h3B, 8'h76,
        8'hF2, 8'hE5, 8'hCB, 8'h97, 8'h2F, 8'h5E, 8'hBC, 8'h79,
        8'hE6, 8'hCD, 8'h9B, 8'h37, 8'h6E, 8'hDC, 8'hB9, 8'h73,
        8'hE9, 8'hD5, 8'hAB, 8'h57, 8'h9E, 8'h5D, 8'hBA, 8'h75,
        8'hDA, 8'hB5, 8'h6B, 8'hD6, 8'hAD, 8'h5B, 8'hB6, 8'h6D,
        8'hFC, 8'hF9, 8'hF3, 8'hE7, 8'hCF, 8'h9F, 8'h3F, 8'h7E,
        8'hFA, 8'hF5, 8'hEB, 8'hD7, 8'hAF, 8'h5F, 8'hBE, 8'h7D,
        8'hF6, 8'hED, 8'hDB, 8'hB7, 8'h6F, 8'hDE, 8'hBD, 8'h7B,
        8'hEE, 8'hDD, 8'hBB, 8'h77,
        8'hFE, 8'hFD, 8'hFB, 8'hF7, 8'hEF, 8'hDF, 8'hBF, 8'h7F,
        8'hFF
    };

    function automatic logic [6:0] group_size(input logic [3:0] nb);
        logic [8:0] diff;
        diff = GROUP_START[nb + 4'd1] - GROUP_START[nb];
        return diff[6:0];
    endfunction

endpackage
`default_nettype wire

FILE: hdl/rbei_thresh.sv
// Sequential builder of the eight cumulative error thresholds.
`default_nettype none
module rbei_thresh (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              start,
    input  wire logic [28:0]       p_in,
    output logic                   busy,
    output rbei_pkg::thr_arr_t     thresholds
);
    import rbei_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL_LO = 3'd1;
    localparam logic [2:0] ST_MUL_HI = 3'd2;
    localparam logic [2:0] ST_SCALE  = 3'd3;
    localparam logic [2:0] ST_ACC    = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [2:0]  i_reg, i_next;
    logic [2:0]  j_reg, j_next;
    logic [28:0] p_reg, p_next;
    logic [28:0] q_reg, q_next;
    logic [35:0] term_reg, term_next;
    logic [46:0] lo_reg, lo_next;
    logic [42:0] scaled_reg, scaled_next;
    logic [43:0] sum_reg, sum_next;
    thr_arr_t    thr_reg, thr_next;

    logic [28:0] op;
    logic [46:0] hi_prod;
    logic [64:0] full_prod;
    logic [43:0] acc;
    logic [28:0] thr_val;
    logic [28:0] p_sat;

    assign op        = (j_reg < i_reg) ? p_reg : q_reg;
    assign hi_prod   = {29'b0, term_reg[35:18]} * {18'b0, op};
    assign full_prod = {hi_prod, 18'b0} + {18'b0, lo_reg};
    assign acc       = sum_reg + {1'b0, scaled_reg};
    assign thr_val   = acc[35:7] + {28'b0, acc[6]};
    assign p_sat     = (p_in > ONE_Q28) ? ONE_Q28 : p_in;

    always_comb begin
        state_next  = state_reg;
        i_next      = i_reg;
        j_next      = j_reg;
        p_next      = p_reg;
        q_next      = q_reg;
        term_next   = term_reg;
        lo_next     = lo_reg;
        scaled_next = scaled_reg;
        sum_next    = sum_reg;
        thr_next    = thr_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    p_next     = p_sat;
                    q_next     = ONE_Q28 - p_sat;
                    term_next  = TERM_ONE;
                    sum_next   = '0;
                    i_next     = '0;
                    j_next     = '0;
                    state_next = ST_MUL_LO;
                end
            end
            ST_MUL_LO: begin
                lo_next    = {29'b0, term_reg[17:0]} * {18'b0, op};
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI: begin
                term_next  = full_prod[63:28];
                j_next     = j_reg + 3'd1;
                state_next = (j_reg == 3'd7) ? ST_SCALE : ST_MUL_LO;
            end
            ST_SCALE: begin
                scaled_next = {7'b0, term_reg} * {36'b0, group_size({1'b0, i_reg})};
                state_next  = ST_ACC;
            end
            ST_ACC: begin
                sum_next        = acc;
                thr_next[i_reg] = thr_val;
                term_next       = TERM_ONE;
                j_next          = '0;
                i_next          = i_reg + 3'd1;
                state_next      = (i_reg == 3'd7) ? ST_IDLE : ST_MUL_LO;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            for (int k = 0; k < 8; k++) begin
                thr_reg[k] <= ONE_Q28;
            end
        end else begin
            state_reg <= state_next;
            thr_reg   <= thr_next;
        end
        i_reg      <= i_next;
        j_reg      <= j_next;
        p_reg      <= p_next;
        q_reg      <= q_next;
        term_reg   <= term_next;
        lo_reg     <= lo_next;
        scaled_reg <= scaled_next;
        sum_reg    <= sum_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign thresholds = thr_reg;

endmodule
`default_nettype wire

FILE: hdl/rbei_pipe.sv
// Four-stage byte datapath: group select, reciprocal multiply, remainder, mask apply.
`default_nettype none
module rbei_pipe (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire rbei_pkg::ctrl_t    ctrl,
    input  wire rbei_pkg::thr_arr_t thresholds,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_data_byte,
    input  wire logic [27:0]        s_rand_level,
    input  wire logic [25:0]        s_rand_pick,
    input  wire logic               s_last_in,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_out_byte,
    output logic [3:0]              m_bits_hit,
    output logic                    m_last_out
);
    import rbei_pkg::*;

    logic adv1, adv2, adv3, adv4;
    logic v1_reg, v2_reg, v3_reg, v4_reg;

    logic [7:0]  d1_reg, d2_reg, d3_reg;
    logic        l1_reg, l2_reg, l3_reg;
    logic        h1_reg, h2_reg, h3_reg;
    logic [3:0]  nb1_reg, nb2_reg, nb3_reg;
    logic [25:0] pick1_reg;
    logic [24:0] x2_reg;
    logic [2:0]  low2_reg;
    logic        d35_2_reg;
    logic [54:0] prod2_reg;
    logic [7:0]  idx3_reg;
    logic [7:0]  out_reg;
    logic [3:0]  hit_reg;
    logic        last_reg;

    logic [7:0]  gt;
    logic [3:0]  nb_c;
    logic        hit_c;
    logic [24:0] x_c;
    logic        d35_c;
    logic [54:0] prod_c;
    logic [22:0] q3;
    logic [5:0]  div3;
    logic [28:0] qd3;
    logic [6:0]  r_raw, r_fix, rem_c;
    logic [7:0]  idx_c;
    logic [7:0]  mask4;
    logic [7:0]  out_c;

    assign adv4    = !v4_reg || m_ready;
    assign adv3    = !v3_reg || adv4;
    assign adv2    = !v2_reg || adv3;
    assign adv1    = !v1_reg || adv2;
    assign s_ready = adv1 && !ctrl.busy;

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            gt[k] = {1'b0, s_rand_level} > thresholds[k];
        end
        nb_c = 4'd8;
        for (int k = 7; k >= 1; k--) begin
            if (!gt[k]) begin
                nb_c = 4'(k);
            end
        end
        hit_c = ctrl.active && (thresholds[0] < ONE_Q28) && gt[0];
    end

    always_comb begin
        x_c   = '0;
        d35_c = 1'b0;
        unique case (nb1_reg)
            4'd2, 4'd6: x_c = {1'b0, pick1_reg[25:2]};
            4'd3, 4'd5: x_c = {2'b0, pick1_reg[25:3]};
            4'd4: begin
                x_c   = pick1_reg[25:1];
                d35_c = 1'b1;
            end
            default: x_c = '0;
        endcase
        prod_c = {30'b0, x_c} * {25'b0, (d35_c ? RECIP35 : RECIP7)};
    end

    always_comb begin
        q3    = prod2_reg[54:32];
        div3  = d35_2_reg ? 6'd35 : 6'd7;
        qd3   = {6'b0, q3} * {23'b0, div3};
        r_raw = x2_reg[6:0] - qd3[6:0];
        r_fix = (r_raw >= {1'b0, div3}) ? (r_raw - {1'b0, div3}) : r_raw;
        unique case (nb2_reg)
            4'd1, 4'd7:  rem_c = {4'b0, low2_reg};
            4'd2, 4'd6:  rem_c = {2'b0, r_fix[2:0], low2_reg[1:0]};
            4'd3, 4'd5:  rem_c = {1'b0, r_fix[2:0], low2_reg};
            4'd4:        rem_c = {r_fix[5:0], low2_reg[0]};
            default:     rem_c = '0;
        endcase
        idx_c = GROUP_START[nb2_reg][7:0] + {1'b0, rem_c};
    end

    always_comb begin
        mask4 = MASK_TABLE[idx3_reg];
        unique case (ctrl.kind)
            KIND_CLEAR: out_c = d3_reg & ~mask4;
            KIND_SET:   out_c = d3_reg | mask4;
            default:    out_c = d3_reg ^ mask4;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (adv1) v1_reg <= s_valid && s_ready;
            if (adv2) v2_reg <= v1_reg;
            if (adv3) v3_reg <= v2_reg;
            if (adv4) v4_reg <= v3_reg;
        end
        if (adv1) begin
            d1_reg    <= s_data_byte;
            l1_reg    <= s_last_in;
            h1_reg    <= hit_c;
            nb1_reg   <= nb_c;
            pick1_reg <= s_rand_pick;
        end
        if (adv2) begin
            d2_reg    <= d1_reg;
            l2_reg    <= l1_reg;
            h2_reg    <= h1_reg;
            nb2_reg   <= nb1_reg;
            x2_reg    <= x_c;
            low2_reg  <= pick1_reg[2:0];
            d35_2_reg <= d35_c;
            prod2_reg <= prod_c;
        end
        if (adv3) begin
            d3_reg   <= d2_reg;
            l3_reg   <= l2_reg;
            h3_reg   <= h2_reg;
            nb3_reg  <= nb2_reg;
            idx3_reg <= idx_c;
        end
        if (adv4) begin
            out_reg  <= h3_reg ? out_c : d3_reg;
            hit_reg  <= h3_reg ? nb3_reg : 4'd0;
            last_reg <= l3_reg;
        end
    end

    assign m_valid    = v4_reg;
    assign m_out_byte = out_reg;
    assign m_bits_hit = hit_reg;
    assign m_last_out = last_reg;

endmodule
`default_nettype wire

FILE: hdl/random_bit_error_injector.sv
// Top level: configuration registers, threshold builder and byte pipeline.
// An accepted byte passes group select, reciprocal multiply, remainder and mask apply.
// Throughput: one byte per cycle; the pipeline stalls per stage without loss.
// Writing the error probability starts a rebuild of the thresholds, during which
// no input or configuration transaction is accepted.
// Reset: thresholds pass bytes through, the corruption mode is flip, active is set.
`default_nettype none
module random_bit_error_injector (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [28:0] cfg_data,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_data_byte,
    input  wire logic [27:0] s_rand_level,
    input  wire logic [25:0] s_rand_pick,
    input  wire logic        s_last_in,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_out_byte,
    output logic [3:0]       m_bits_hit,
    output logic             m_last_out
);
    import rbei_pkg::*;

    logic [1:0] kind_q_reg;
    logic       active_reg;
    logic       busy;
    logic       cfg_write;
    thr_arr_t   thresholds;
    ctrl_t      ctrl;

    assign cfg_ready = !busy;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kind_q_reg <= KIND_FLIP;
            active_reg <= 1'b1;
        end else if (cfg_write) begin
            if (cfg_index == REG_MODE)   kind_q_reg <= cfg_data[1:0];
            if (cfg_index == REG_ACTIVE) active_reg <= cfg_data[0];
        end
    end

    assign ctrl.kind   = kind_q_reg;
    assign ctrl.active = active_reg;
    assign ctrl.busy   = busy;

    rbei_thresh u_thresh (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (cfg_write && (cfg_index == REG_PROB)),
        .p_in       (cfg_data),
        .busy       (busy),
        .thresholds (thresholds)
    );

    rbei_pipe u_pipe (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .ctrl         (ctrl),
        .thresholds   (thresholds),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data_byte  (s_data_byte),
        .s_rand_level (s_rand_level),
        .s_rand_pick  (s_rand_pick),
        .s_last_in    (s_last_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_bits_hit   (m_bits_hit),
        .m_last_out   (m_last_out)
    );

endmodule
`default_nettype wire

FILE: hdl/rbei_checker.sv
// Port-level assertions for the random bit error injector, with its bind.
`default_nettype none
module rbei_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        cfg_valid,
    input wire logic        cfg_ready,
    input wire logic [1:0]  cfg_index,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_out_byte,
    input wire logic [3:0]  m_bits_hit
);
    import rbei_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_byte) && $stable(m_bits_hit))
        else $error("Stalled result transaction changed.");

    a_hit_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_bits_hit <= 4'd8)
        else $error("Result reports more than eight corrupted bits.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid right after reset.");

    a_build_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready && (cfg_index == REG_PROB) |=> !s_ready && !cfg_ready)
        else $error("Transactions accepted while thresholds are rebuilt.");

endmodule

bind random_bit_error_injector rbei_checker u_rbei_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_out_byte (m_out_byte),
    .m_bits_hit (m_bits_hit)
);
`default_nettype wire
